### src/cfb_pkg.sv
// Shared types, register indexes and check-value helpers for the command frame builder.
package cfb_pkg;

  localparam logic [15:0] CHECK_POLY = 16'h1021;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_SECOND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_FIRST  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_SECOND = 2'd3;

  typedef struct packed {
    logic        start;
    logic        has;
    logic        last;
    logic [7:0]  addr;
    logic [15:0] cmd;
    logic [15:0] len;
    logic [7:0]  pay;
  } cfb_cmd_t;

  typedef struct packed {
    logic [7:0] head_first;
    logic [7:0] head_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
  } cfb_cfg_t;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_HEAD0,
    STEP_HEAD1,
    STEP_ADDR_HI,
    STEP_ADDR,
    STEP_CMD_HI,
    STEP_CMD_LO,
    STEP_LEN_HI,
    STEP_LEN_LO,
    STEP_PAY,
    STEP_CHK_HI,
    STEP_CHK_LO,
    STEP_TAIL0,
    STEP_TAIL1
  } cfb_step_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] ^ b[i]) begin
        c = {c[14:0], 1'b0} ^ CHECK_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic cfb_step_t after_payload(input cfb_cmd_t c);
    return c.last ? STEP_CHK_HI : STEP_IDLE;
  endfunction

  function automatic cfb_step_t first_step(input cfb_cmd_t c);
    cfb_step_t s;
    if (c.start) begin
      s = STEP_HEAD0;
    end else if (c.has) begin
      s = STEP_PAY;
    end else begin
      s = after_payload(c);
    end
    return s;
  endfunction

  function automatic cfb_step_t next_step(input cfb_step_t s, input cfb_cmd_t c);
    cfb_step_t n;
    unique case (s)
      STEP_HEAD0:   n = STEP_HEAD1;
      STEP_HEAD1:   n = STEP_ADDR_HI;
      STEP_ADDR_HI: n = STEP_ADDR;
      STEP_ADDR:    n = STEP_CMD_HI;
      STEP_CMD_HI:  n = STEP_CMD_LO;
      STEP_CMD_LO:  n = STEP_LEN_HI;
      STEP_LEN_HI:  n = STEP_LEN_LO;
      STEP_LEN_LO:  n = c.has ? STEP_PAY : after_payload(c);
      STEP_PAY:     n = after_payload(c);
      STEP_CHK_HI:  n = STEP_CHK_LO;
      STEP_CHK_LO:  n = STEP_TAIL0;
      STEP_TAIL0:   n = STEP_TAIL1;
      STEP_TAIL1:   n = STEP_IDLE;
      STEP_IDLE:    n = STEP_IDLE;
      default:      n = STEP_IDLE;
    endcase
    return n;
  endfunction

endpackage

### src/cfb_front.sv
// Front end: accepts input items, tracks the open frame and drops items with no output.
module cfb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_frame_start,
  input  logic [7:0]        in_module_addr,
  input  logic [15:0]       in_command,
  input  logic [15:0]       in_declared_length,
  input  logic [7:0]        in_payload_byte,
  input  logic              in_has_byte,
  input  logic              in_last_byte,
  input  logic              q_full,
  output logic              q_push,
  output cfb_pkg::cfb_cmd_t q_data
);

  logic in_frame_r;
  logic in_frame_nxt;
  logic open_c;
  logic accept_c;
  logic useful_c;

  assign open_c   = in_frame_start | in_frame_r;
  assign in_ready = ~q_full;
  assign accept_c = in_valid & in_ready;

  always_comb begin
    q_data.start = in_frame_start;
    q_data.has   = open_c & in_has_byte;
    q_data.last  = open_c & in_last_byte;
    q_data.addr  = in_module_addr;
    q_data.cmd   = in_command;
    q_data.len   = in_declared_length;
    q_data.pay   = in_payload_byte;
  end

  assign useful_c = q_data.start | q_data.has | q_data.last;
  assign q_push   = accept_c & useful_c;

  always_comb begin
    in_frame_nxt = in_frame_r;
    if (accept_c && open_c) begin
      in_frame_nxt = ~in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

### src/cfb_fifo.sv
// Short item queue between the front end and the byte sequencer.
module cfb_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfb_pkg::cfb_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output cfb_pkg::cfb_cmd_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfb_pkg::cfb_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/cfb_back.sv
// Back end: byte sequencer, running check value, config registers and output register.
module cfb_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cfb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                q_valid,
  input  cfb_pkg::cfb_cmd_t                   q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_byte,
  output logic                                out_frame_end,
  output logic                                out_run_last
);

  cfb_pkg::cfb_cfg_t  cfg_r;
  cfb_pkg::cfb_step_t state_r;
  cfb_pkg::cfb_step_t state_nxt;
  cfb_pkg::cfb_step_t act_step;
  cfb_pkg::cfb_step_t after_step;
  cfb_pkg::cfb_cmd_t  cur_r;
  cfb_pkg::cfb_cmd_t  act_cmd;
  logic [15:0]        crc_r;
  logic [15:0]        crc_nxt;
  logic [7:0]         byte_c;
  logic               covered_c;
  logic               adv;
  logic               out_valid_r;
  logic [7:0]         out_byte_r;
  logic               out_frame_end_r;
  logic               out_run_last_r;

  assign adv     = ~out_valid_r | out_ready;
  assign act_cmd = (state_r == cfb_pkg::STEP_IDLE) ? q_head : cur_r;
  assign q_pop   = adv & (state_r == cfb_pkg::STEP_IDLE) & q_valid;

  always_comb begin
    if (state_r != cfb_pkg::STEP_IDLE) begin
      act_step = state_r;
    end else if (q_valid) begin
      act_step = cfb_pkg::first_step(q_head);
    end else begin
      act_step = cfb_pkg::STEP_IDLE;
    end
  end

  // next state
  always_comb begin
    after_step = cfb_pkg::next_step(act_step, act_cmd);
    state_nxt  = adv ? after_step : state_r;
  end

  // byte select and check value update
  always_comb begin
    byte_c    = '0;
    covered_c = 1'b0;
    crc_nxt   = crc_r;
    unique case (act_step)
      cfb_pkg::STEP_HEAD0: begin
        byte_c  = cfg_r.head_first;
        crc_nxt = '0;
      end
      cfb_pkg::STEP_HEAD1:   byte_c = cfg_r.head_second;
      cfb_pkg::STEP_ADDR_HI: begin
        byte_c    = 8'h00;
        covered_c = 1'b1;
      end
      cfb_pkg::STEP_ADDR: begin
        byte_c    = act_cmd.addr;
        covered_c = 1'b1;
      end
      cfb_pkg::STEP_CMD_HI: begin
        byte_c    = act_cmd.cmd[15:8];
        covered_c = 1'b1;
      end
      cfb_pkg::STEP_CMD_LO: begin
        byte_c    = act_cmd.cmd[7:0];
        covered_c = 1'b1;
      end
      cfb_pkg::STEP_LEN_HI: begin
        byte_c    = act_cmd.len[15:8];
        covered_c = 1'b1;
      end
      cfb_pkg::STEP_LEN_LO: begin
        byte_c    = act_cmd.len[7:0];
        covered_c = 1'b1;
      end
      cfb_pkg::STEP_PAY: begin
        byte_c    = act_cmd.pay;
        covered_c = 1'b1;
      end
      cfb_pkg::STEP_CHK_HI:  byte_c = crc_r[15:8];
      cfb_pkg::STEP_CHK_LO:  byte_c = crc_r[7:0];
      cfb_pkg::STEP_TAIL0:   byte_c = cfg_r.tail_first;
      cfb_pkg::STEP_TAIL1:   byte_c = cfg_r.tail_second;
      cfb_pkg::STEP_IDLE:    byte_c = '0;
      default:               byte_c = '0;
    endcase
    if (covered_c) begin
      crc_nxt = cfb_pkg::crc_byte(crc_r, byte_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfb_pkg::REG_HEAD_FIRST:  cfg_r.head_first  <= cfg_data;
        cfb_pkg::REG_HEAD_SECOND: cfg_r.head_second <= cfg_data;
        cfb_pkg::REG_TAIL_FIRST:  cfg_r.tail_first  <= cfg_data;
        cfb_pkg::REG_TAIL_SECOND: cfg_r.tail_second <= cfg_data;
        default:                  cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfb_pkg::STEP_IDLE;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        crc_r       <= crc_nxt;
        out_valid_r <= (act_step != cfb_pkg::STEP_IDLE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (adv) begin
      out_byte_r      <= byte_c;
      out_frame_end_r <= (act_step == cfb_pkg::STEP_TAIL1);
      out_run_last_r  <= (after_step == cfb_pkg::STEP_IDLE);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;
  assign out_run_last  = out_run_last_r;

`ifndef SYNTHESIS
  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end_r |-> out_run_last_r)
    else $error("frame end byte not marked as last of its item");

  a_chk_lo_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cfb_pkg::STEP_CHK_LO |=>
      (state_r == cfb_pkg::STEP_CHK_LO || state_r == cfb_pkg::STEP_TAIL0))
    else $error("check low byte not followed by tail");

  a_busy_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != cfb_pkg::STEP_IDLE |-> out_valid_r)
    else $error("sequencer busy without a pending output byte");
`endif

endmodule

### src/command_frame_builder_crc16_unit.sv
// Top level of the command frame builder with 16-bit check value.
// An accepted item enters the queue; the idle sequencer pops it and registers its first byte.
// Throughput: one output byte per cycle while items wait and out_ready does not stall; the
// sequencer takes a new item only when idle. Items causing no byte are dropped at entry.
// Reset: synchronous active-low rst_n clears config registers, frame state, queue and output valid.
module command_frame_builder_crc16_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_frame_start,
  input  logic [7:0]                      in_module_addr,
  input  logic [15:0]                     in_command,
  input  logic [15:0]                     in_declared_length,
  input  logic [7:0]                      in_payload_byte,
  input  logic                            in_has_byte,
  input  logic                            in_last_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output logic                            out_frame_end,
  output logic                            out_run_last,
  input  logic                            cfg_we,
  input  logic [cfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  cfb_pkg::cfb_cmd_t q_data;
  cfb_pkg::cfb_cmd_t q_head;

  cfb_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_frame_start     (in_frame_start),
    .in_module_addr     (in_module_addr),
    .in_command         (in_command),
    .in_declared_length (in_declared_length),
    .in_payload_byte    (in_payload_byte),
    .in_has_byte        (in_has_byte),
    .in_last_byte       (in_last_byte),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_data             (q_data)
  );

  cfb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  cfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule
